// ----- design/keypad_password_lock_with_power_arm_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the password lock
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PASSWORD_LOCK_WITH_POWER_ARM_MACROS_SVH
`define KEYPAD_PASSWORD_LOCK_WITH_POWER_ARM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kpl_pkg.sv -----
// ----------------------------------------------------------------------------
// kpl_pkg
// Constants, codes, control word layout and microcode for the password lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

  localparam int unsigned MaxChars = 256;

  localparam logic [7:0] KeyEntry   = 8'h15;
  localparam logic [7:0] KeyEnter   = 8'd28;
  localparam int unsigned ReleaseBit = 7;

  localparam logic [1:0] PsUnplugged = 2'd0;
  localparam logic [1:0] PsPlugged   = 2'd1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SAVED    = 2'd1,
    EV_UNLOCK   = 2'd2,
    EV_MISMATCH = 2'd3
  } ev_e;

  // Datapath operation selected by the control word.
  typedef enum logic [2:0] {
    UOP_CLEAR    = 3'd0,
    UOP_WAIT     = 3'd1,
    UOP_DECODE   = 3'd2,
    UOP_CMP_READ = 3'd3,
    UOP_CMP_END  = 3'd4,
    UOP_PUSH     = 3'd5
  } uop_e;

  // Condition that keeps the step counter where it is.
  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_NO_INPUT = 2'd1,
    HOLD_OUT_BUSY = 2'd2,
    HOLD_NOT_LAST = 2'd3
  } hold_e;

  // Condition under which the step counter loads the jump target.
  typedef enum logic [1:0] {
    BR_NEVER  = 2'd0,
    BR_ALWAYS = 2'd1,
    BR_NO_CMP = 2'd2
  } br_e;

  localparam int unsigned StepW = 3;

  localparam logic [StepW-1:0] StepClear   = 3'd0;
  localparam logic [StepW-1:0] StepWait    = 3'd1;
  localparam logic [StepW-1:0] StepDecode  = 3'd2;
  localparam logic [StepW-1:0] StepCmpRead = 3'd3;
  localparam logic [StepW-1:0] StepCmpEnd  = 3'd4;
  localparam logic [StepW-1:0] StepPush    = 3'd5;

  typedef struct packed {
    uop_e             uop;
    hold_e            hold;
    br_e              br;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_blocked;
    logic idx_last;
    logic need_cmp;
  } stat_t;

  // Microprogram: one control word per step.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t cw;
    unique case (step)
      StepClear:   cw = '{UOP_CLEAR,    HOLD_NOT_LAST, BR_NEVER,  StepWait};
      StepWait:    cw = '{UOP_WAIT,     HOLD_NO_INPUT, BR_NEVER,  StepDecode};
      StepDecode:  cw = '{UOP_DECODE,   HOLD_NONE,     BR_NO_CMP, StepPush};
      StepCmpRead: cw = '{UOP_CMP_READ, HOLD_NOT_LAST, BR_NEVER,  StepCmpEnd};
      StepCmpEnd:  cw = '{UOP_CMP_END,  HOLD_NONE,     BR_NEVER,  StepPush};
      StepPush:    cw = '{UOP_PUSH,     HOLD_OUT_BUSY, BR_ALWAYS, StepWait};
      default:     cw = '{UOP_WAIT,     HOLD_NONE,     BR_ALWAYS, StepWait};
    endcase
    return cw;
  endfunction

endpackage

// ----- design/kpl_if.sv -----
// ----------------------------------------------------------------------------
// kpl_in_if / kpl_out_if
// Valid/ready channels for lock events and lock results.
// ----------------------------------------------------------------------------
interface kpl_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] scan_code;
  logic [1:0] power_status;

  modport source (output valid, output opcode, output scan_code, output power_status,
                  input ready);
  modport sink   (input valid, input opcode, input scan_code, input power_status,
                  output ready);
endinterface

interface kpl_out_if;
  logic       valid;
  logic       ready;
  logic       armed;
  logic       unlocked;
  logic       entry_enabled;
  logic [1:0] event_code;

  modport source (output valid, output armed, output unlocked, output entry_enabled,
                  output event_code, input ready);
  modport sink   (input valid, input armed, input unlocked, input entry_enabled,
                  input event_code, output ready);
endinterface

// ----- design/kpl_store.sv -----
// ----------------------------------------------------------------------------
// kpl_store
// Password and attempt character memories, one write port each, a shared read
// address and registered read data.
// ----------------------------------------------------------------------------
module kpl_store #(
  parameter int unsigned Depth = kpl_pkg::MaxChars,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             pw_we_i,
  input  logic             at_we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       pw_rd_o,
  output logic [7:0]       at_rd_o
);

  logic [7:0] pw_mem [Depth];
  logic [7:0] at_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (pw_we_i) begin
      pw_mem[wr_addr_i] <= wr_data_i;
    end
    pw_rd_o <= pw_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (at_we_i) begin
      at_mem[wr_addr_i] <= wr_data_i;
    end
    at_rd_o <= at_mem[rd_addr_i];
  end

endmodule

// ----- design/kpl_seq.sv -----
// ----------------------------------------------------------------------------
// kpl_seq
// Step counter and control store: holds, steps or jumps on datapath status.
// ----------------------------------------------------------------------------
module kpl_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kpl_pkg::stat_t  stat_i,
  output kpl_pkg::ctrl_t  ctrl_o
);

  logic [kpl_pkg::StepW-1:0] upc_q, upc_d;
  logic                      hold;
  logic                      jump;

  assign ctrl_o = kpl_pkg::ucode(upc_q);

  always_comb begin
    unique case (ctrl_o.hold)
      kpl_pkg::HOLD_NONE:     hold = 1'b0;
      kpl_pkg::HOLD_NO_INPUT: hold = !stat_i.in_valid;
      kpl_pkg::HOLD_OUT_BUSY: hold = stat_i.out_blocked;
      kpl_pkg::HOLD_NOT_LAST: hold = !stat_i.idx_last;
      default:                hold = 1'b0;
    endcase
    unique case (ctrl_o.br)
      kpl_pkg::BR_NEVER:  jump = 1'b0;
      kpl_pkg::BR_ALWAYS: jump = 1'b1;
      kpl_pkg::BR_NO_CMP: jump = !stat_i.need_cmp;
      default:            jump = 1'b0;
    endcase
    if (hold) begin
      upc_d = upc_q;
    end else if (jump) begin
      upc_d = ctrl_o.target;
    end else begin
      upc_d = upc_q + kpl_pkg::StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= kpl_pkg::StepClear;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- design/keypad_password_lock_with_power_arm.sv -----
// ----------------------------------------------------------------------------
// keypad_password_lock_with_power_arm
// Password lock fed by keyboard scancodes and power adapter samples.
// ----------------------------------------------------------------------------
// Usage:
// evt_i takes one word per event: a keyboard scancode (opcode 0) or a power
// adapter status sample (opcode 1). res_o gives exactly one word per event:
// the armed, unlocked and entry flags after that event and an event code.
// A small microprogram sequences the work; its step counter sets the timing.
// An ordinary event steps the sequencer through wait, decode and push, and
// its result is loaded into the output register at push. An Enter that
// compares the stores goes from decode through a compare-read walk and a
// compare end to push; the walk reads both character memories one entry a
// cycle through their shared read address, and the attempt store is cleared
// on the same walk.
// After reset the block runs a clearing pass over all MAX_CHARS entries of
// both memories, with evt_i.ready low, before the first event is taken.
// The result waits in an output register; a new event is accepted while it
// waits, but the next result stalls the sequencer until res_o.ready has
// taken the previous one.
// ----------------------------------------------------------------------------
`include "keypad_password_lock_with_power_arm_macros.svh"

module keypad_password_lock_with_power_arm #(
  parameter int unsigned MAX_CHARS = kpl_pkg::MaxChars
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kpl_in_if.sink       evt_i,
  kpl_out_if.source    res_o
);

  localparam int unsigned AddrW  = $clog2(MAX_CHARS);
  localparam int unsigned CountW = $clog2(MAX_CHARS + 1);

  kpl_pkg::ctrl_t ctrl;
  kpl_pkg::stat_t stat;

  // Flags and shared character count.
  logic              armed_q, unlock_q, entry_q;
  logic [CountW-1:0] count_q;
  kpl_pkg::ev_e      ev_q;

  // Latched event word.
  logic       opc_q;
  logic [7:0] sc_q;
  logic [1:0] ps_q;

  // Store walk.
  logic [AddrW-1:0] idx_q;
  logic             rd_vld_q;
  logic             mism_q;
  logic [7:0]       pw_rd, at_rd;
  logic             idx_last;

  // Output register.
  logic       out_vld_q;
  logic       out_armed_q, out_unlock_q, out_entry_q;
  logic [1:0] out_ev_q;

  logic in_fire, push_fire, out_blocked;
  logic entry_n, setup, unl, typing, is_enter, key_enter, key_char, need_cmp;
  logic mism_end;

  logic             pw_we, at_we;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;

  assign idx_last    = idx_q == AddrW'(MAX_CHARS - 1);
  assign out_blocked = out_vld_q && !res_o.ready;
  assign in_fire     = evt_i.valid && evt_i.ready;
  assign push_fire   = (ctrl.uop == kpl_pkg::UOP_PUSH) && !out_blocked;
  assign evt_i.ready = ctrl.uop == kpl_pkg::UOP_WAIT;

  assign stat = '{in_valid: evt_i.valid, out_blocked: out_blocked,
                  idx_last: idx_last, need_cmp: need_cmp};

  kpl_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Key event decode on the latched word.
  always_comb begin
    entry_n   = entry_q || (sc_q == kpl_pkg::KeyEntry);
    setup     = armed_q && !unlock_q && entry_n;
    unl       = !armed_q && !unlock_q && entry_n;
    typing    = !opc_q && (setup || unl) && !sc_q[kpl_pkg::ReleaseBit];
    is_enter  = sc_q == kpl_pkg::KeyEnter;
    key_enter = typing && is_enter && (count_q != '0);
    key_char  = typing && !is_enter && (count_q < CountW'(MAX_CHARS));
    need_cmp  = key_enter && unl;
    mism_end  = mism_q || (pw_rd != at_rd);
  end

  // Memory write port selection.
  always_comb begin
    pw_we   = 1'b0;
    at_we   = 1'b0;
    wr_addr = idx_q;
    wr_data = 8'h00;
    case (ctrl.uop)
      kpl_pkg::UOP_CLEAR: begin
        pw_we = 1'b1;
        at_we = 1'b1;
      end
      kpl_pkg::UOP_CMP_READ: begin
        at_we = 1'b1;
      end
      kpl_pkg::UOP_DECODE: begin
        pw_we   = key_char && setup;
        at_we   = key_char && !setup;
        wr_addr = count_q[AddrW-1:0];
        wr_data = sc_q;
      end
      default: begin
      end
    endcase
  end

  kpl_store #(
    .Depth (MAX_CHARS)
  ) u_store (
    .clk_i     (clk_i),
    .pw_we_i   (pw_we),
    .at_we_i   (at_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (idx_q),
    .pw_rd_o   (pw_rd),
    .at_rd_o   (at_rd)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      opc_q <= evt_i.opcode;
      sc_q  <= evt_i.scan_code;
      ps_q  <= evt_i.power_status;
    end
    if (ctrl.uop == kpl_pkg::UOP_DECODE) begin
      mism_q <= 1'b0;
    end else if (ctrl.uop == kpl_pkg::UOP_CMP_READ && rd_vld_q) begin
      mism_q <= mism_end;
    end
    if (push_fire) begin
      out_armed_q  <= armed_q;
      out_unlock_q <= unlock_q;
      out_entry_q  <= entry_q;
      out_ev_q     <= ev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b1;
      unlock_q  <= 1'b0;
      entry_q   <= 1'b1;
      count_q   <= '0;
      ev_q      <= kpl_pkg::EV_NONE;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl.uop == kpl_pkg::UOP_CMP_READ;
      if (ctrl.uop == kpl_pkg::UOP_CLEAR || ctrl.uop == kpl_pkg::UOP_CMP_READ) begin
        idx_q <= idx_last ? '0 : idx_q + AddrW'(1);
      end
      if (ctrl.uop == kpl_pkg::UOP_DECODE) begin
        if (!opc_q) begin
          if (key_enter) begin
            entry_q <= 1'b0;
            count_q <= '0;
          end else begin
            entry_q <= entry_n;
            if (key_char) begin
              count_q <= count_q + CountW'(1);
            end
          end
          if (key_enter && setup) begin
            unlock_q <= 1'b1;
            ev_q     <= kpl_pkg::EV_SAVED;
          end else begin
            ev_q <= kpl_pkg::EV_NONE;
          end
        end else begin
          ev_q <= kpl_pkg::EV_NONE;
          if (ps_q == kpl_pkg::PsUnplugged) begin
            if (armed_q && unlock_q && !entry_q) begin
              armed_q  <= 1'b0;
              unlock_q <= 1'b0;
            end
          end else if (ps_q == kpl_pkg::PsPlugged) begin
            if (!(armed_q && !unlock_q && entry_q)) begin
              armed_q  <= 1'b1;
              unlock_q <= 1'b1;
            end
          end
        end
      end
      if (ctrl.uop == kpl_pkg::UOP_CMP_END) begin
        unlock_q <= !mism_end;
        ev_q     <= mism_end ? kpl_pkg::EV_MISMATCH : kpl_pkg::EV_UNLOCK;
      end
      if (push_fire) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.armed         = out_armed_q;
  assign res_o.unlocked      = out_unlock_q;
  assign res_o.entry_enabled = out_entry_q;
  assign res_o.event_code    = out_ev_q;

  `KPL_ASSERT_NXT(a_push_returns_to_wait, clk_i, rst_ni, push_fire, ctrl.uop == kpl_pkg::UOP_WAIT, "sequencer did not return to wait after a result")
  `KPL_ASSERT_NXT(a_cmp_sets_unlock, clk_i, rst_ni, ctrl.uop == kpl_pkg::UOP_CMP_END, unlock_q == (ev_q == kpl_pkg::EV_UNLOCK), "unlock flag disagrees with compare outcome")
  `KPL_ASSERT_IMP(a_count_bounded, clk_i, rst_ni, 1'b1, count_q <= CountW'(MAX_CHARS), "character count beyond capacity")
  `KPL_ASSERT_IMP(a_saved_closes_entry, clk_i, rst_ni, push_fire && ev_q == kpl_pkg::EV_SAVED, !entry_q && unlock_q, "password saved but flags not updated")

endmodule
